@@ hw/rtl/emgf_pkg.sv @@
// Shared types, constants and helper functions of the exponential fit unit.
`default_nettype none

package emgf_pkg;

   localparam int unsigned EXP_TABLE_SIZE = 64;
   localparam int unsigned TAB_BITS       = $clog2(EXP_TABLE_SIZE);
   localparam int unsigned TAYLOR_TERMS   = 20;
   localparam logic [32:0] LOG2E_Q30      = 33'd1549082005;
   localparam logic [63:0] LN2_Q30        = 64'd744261118;
   localparam logic signed [22:0] ARG_LIMIT = 23'sd2097152;

   localparam logic [31:0] INIT_A_RST     = 32'd13107;
   localparam logic [31:0] INIT_B_RST     = 32'd6554;
   localparam logic [31:0] LEARN_RATE_RST = 32'd4294967;
   localparam logic [31:0] STOP_STEP_RST  = 32'd429497;
   localparam logic [17:0] PASS_LIMIT_RST = 18'd200000;

   typedef enum logic [2:0] {
      CSR_INIT_A     = 3'd0,
      CSR_INIT_B     = 3'd1,
      CSR_LEARN_RATE = 3'd2,
      CSR_STOP_STEP  = 3'd3,
      CSR_PASS_LIMIT = 3'd4
   } csr_idx_type;

   typedef enum logic [5:0] {
      ST_IDLE, ST_INIT, ST_PCHK, ST_CINIT, ST_FETCH, ST_MT, ST_MY, ST_TAB, ST_INT,
      ST_SCL, ST_PRED, ST_DIFF, ST_DMUL, ST_G1, ST_G2, ST_G3, ST_CACC,
      ST_DA_GO, ST_DA_WT, ST_DB_GO, ST_DB_WT, ST_UA, ST_UA2, ST_UB, ST_UB2,
      ST_CV_DA, ST_CV_DB, ST_CV_EE, ST_CV_CMP, ST_CD_GO, ST_CD_WT, ST_OUT
   } state_type;

   typedef logic [32:0] exp_tab_type [EXP_TABLE_SIZE+1];

   // 2^(i/size) in Q3.30 by a truncated Taylor series of e^(i*ln2/size)
   function automatic exp_tab_type build_exp_tab();
      exp_tab_type tab;
      logic [63:0] z;
      logic [63:0] term;
      logic [63:0] sum;
      for (int i = 0; i <= int'(EXP_TABLE_SIZE); i++) begin
         z    = (64'(i) * LN2_Q30) / EXP_TABLE_SIZE;
         term = 64'd1 << 30;
         sum  = term;
         for (int j = 1; j <= int'(TAYLOR_TERMS); j++) begin
            term = ((term * z) >> 30) / 64'(j);
            sum  = sum + term;
         end
         tab[i] = sum[32:0];
      end
      return tab;
   endfunction

   localparam exp_tab_type EXP_TAB = build_exp_tab();

   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      if (v > 68'sh0_7FFF_FFFF)       return 32'sh7FFF_FFFF;
      else if (v < -68'sh0_8000_0000) return -32'sh8000_0000;
      else                            return v[31:0];
   endfunction

   function automatic logic signed [63:0] sadd64(input logic signed [63:0] acc,
                                                 input logic signed [31:0] g);
      logic signed [64:0] s;
      s = 65'(acc) + 65'(g);
      if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      else                return s[63:0];
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/emgf_div.sv @@
// Restoring divider, 64-bit unsigned dividend, one quotient bit per cycle.
`default_nettype none

module emgf_div
   import emgf_pkg::*;
#(
   parameter int unsigned DVW = 12
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [63:0]    dividend,
   input  wire logic [DVW-1:0] divisor,
   output logic                done,
   output logic [63:0]         quotient
);

   logic           run_ff, run_in;
   logic           done_ff, done_in;
   logic [5:0]     cnt_ff, cnt_in;
   logic [DVW-1:0] rem_ff, rem_in;
   logic [63:0]    quo_ff, quo_in;
   logic [DVW:0]   rem_sh;
   logic           ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[63]};
      ge      = rem_sh >= {1'b0, divisor};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = dividend;
      end else if (run_ff) begin
         rem_in = ge ? DVW'(rem_sh - {1'b0, divisor}) : rem_sh[DVW-1:0];
         quo_in = {quo_ff[62:0], ge};
         cnt_in = cnt_ff + 6'd1;
         // last quotient bit goes in now
         if (cnt_ff == 6'd63) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

@@ hw/rtl/exp_model_gradient_fit_unit.sv @@
// Top level: point store, fit sequencer around one shared 33x33 multiplier.
// Loading: one item per cycle (start with busy low); busy stays low until the last point.
// Fit: each pass takes 12 sequencer steps per point on the shared multiplier, then two
// divisions for the means; then the cost pass walks the points again, with one division.
// The result strobe rsp_valid lasts one cycle; the receiver cannot stall, so busy drops next.
// Reset (synchronous, high): registers return to defaults, point count and fit state clear.
`default_nettype none

module exp_model_gradient_fit_unit
   import emgf_pkg::*;
#(
   parameter int unsigned MAX_POINTS = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // item input
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_sample_x,
   input  wire logic [31:0] req_sample_y,
   input  wire logic        req_last_point,
   // result
   output logic             rsp_valid,
   output logic [31:0]      rsp_fit_a,
   output logic [31:0]      rsp_fit_b,
   output logic [31:0]      rsp_fit_cost,
   output logic [17:0]      rsp_passes_run,
   output logic             rsp_converged,
   // register writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   localparam int unsigned CW  = $clog2(MAX_POINTS + 1);
   localparam int unsigned AW  = $clog2(MAX_POINTS);
   localparam int unsigned DVW = CW + 1;

   // point store
   logic [31:0] x_mem [MAX_POINTS];
   logic [31:0] y_mem [MAX_POINTS];
   logic signed [31:0] x_rd_ff, y_rd_ff;

   // registers written through the csr port
   logic [31:0] init_a_ff, init_b_ff, learn_rate_ff, stop_step_ff;
   logic [17:0] pass_limit_ff;

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in, n_ff, n_in, idx_ff, idx_in;
   logic          mode_ff, mode_in;   // high while the cost pass runs
   logic signed [31:0] a_ff, a_in, b_ff, b_in;
   logic [17:0]   pass_ff, pass_in;
   logic          conv_ff, conv_in;
   logic [31:0]   cost_ff, cost_in;
   logic signed [65:0] prod_ff, prod_in;
   logic signed [32:0] mul_a, mul_b;
   logic signed [7:0]  k_ff, k_in;
   logic [15:0]   r_ff, r_in;
   logic [32:0]   lo_ff, lo_in, dlt_ff, dlt_in;
   logic [31:0]   e_ff, e_in;
   logic signed [31:0] d_ff, d_in;
   logic signed [63:0] sa_ff, sa_in, sb_ff, sb_in;
   logic [63:0]   csum_ff, csum_in;
   logic signed [31:0] ma_ff, ma_in, mb_ff, mb_in;
   logic signed [32:0] da_ff, da_in, db_ff, db_in;
   logic [32:0]   sq_ff, sq_in;
   logic [33:0]   s_ff, s_in;

   logic          accept;
   logic          div_start, div_done;
   logic [63:0]   div_dvd, div_q;
   logic [DVW-1:0] div_dvs;

   // datapath helpers
   logic signed [65:0] t_full, y_full;
   logic signed [22:0] t_c;
   logic [15:0]   f_w;
   logic [TAB_BITS-1:0] ti;
   logic [TAB_BITS:0]   ti_hi;
   logic [32:0]   v_w;
   logic [34:0]   vsh;
   logic [6:0]    rsh;
   logic [31:0]   e_w;
   logic signed [31:0] g_w, pred_w, na_w;
   logic signed [64:0] q_s;
   logic [64:0]   csum_w;
   logic          last_pt, in_range;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign div_dvs   = mode_ff ? {n_ff, 1'b0} : {1'b0, n_ff};
   assign last_pt   = (idx_ff == n_ff - CW'(1));
   assign in_range  = (da_ff > -33'sd65536) && (da_ff < 33'sd65536) &&
                      (db_ff > -33'sd65536) && (db_ff < 33'sd65536);
   assign prod_in   = mul_a * mul_b;

   // exponential: clamp t, split b*x*log2(e) into 2^k and a table fraction
   always_comb begin
      t_full = prod_ff >>> 16;
      if (t_full > 66'(ARG_LIMIT))       t_c = ARG_LIMIT;
      else if (t_full < -66'(ARG_LIMIT)) t_c = -ARG_LIMIT;
      else                               t_c = t_full[22:0];
      y_full = prod_ff >>> 30;
      f_w    = y_full[15:0];
      ti     = f_w[15 -: TAB_BITS];
      ti_hi  = {1'b0, ti} + (TAB_BITS+1)'(1);
      v_w    = lo_ff + prod_ff[48:16];
      vsh    = '0;
      rsh    = '0;
      if (k_ff >= 8'sd16) begin
         e_w = 32'hFFFF_FFFF;
      end else if (k_ff >= 8'sd14) begin
         vsh = {2'b00, v_w} << k_ff[0];
         e_w = (vsh[34:32] != 3'd0) ? 32'hFFFF_FFFF : vsh[31:0];
      end else begin
         rsh = 7'(8'sd14 - k_ff);
         e_w = 32'(v_w >> rsh);
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;   n_in = n_ff;     idx_in = idx_ff;   mode_in = mode_ff;
      a_in = a_ff;       b_in = b_ff;     pass_in = pass_ff; conv_in = conv_ff;
      cost_in = cost_ff; k_in = k_ff;     r_in = r_ff;       lo_in = lo_ff;
      dlt_in = dlt_ff;   e_in = e_ff;     d_in = d_ff;       sa_in = sa_ff;
      sb_in = sb_ff;     csum_in = csum_ff; ma_in = ma_ff;   mb_in = mb_ff;
      da_in = da_ff;     db_in = db_ff;   sq_in = sq_ff;     s_in = s_ff;
      mul_a = '0;        mul_b = '0;      div_start = 1'b0;  div_dvd = '0;
      g_w    = sat32(68'(prod_ff >>> 16));
      pred_w = g_w;
      na_w   = '0;
      q_s    = '0;
      csum_w = {1'b0, csum_ff} + {1'b0, prod_ff[63:0]};
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // drop points once the store is full, the last one still starts the fit
               if (cnt_ff < CW'(MAX_POINTS)) cnt_in = cnt_ff + CW'(1);
               if (req_last_point) begin
                  n_in     = (cnt_ff < CW'(MAX_POINTS)) ? cnt_ff + CW'(1) : cnt_ff;
                  cnt_in   = '0;
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            a_in     = init_a_ff;
            b_in     = init_b_ff;
            pass_in  = '0;
            state_in = ST_PCHK;
         end
         ST_PCHK: begin
            if (pass_ff < pass_limit_ff) begin
               idx_in = '0; sa_in = '0; sb_in = '0; mode_in = 1'b0;
               state_in = ST_FETCH;
            end else begin
               conv_in  = 1'b0;
               state_in = ST_CINIT;
            end
         end
         ST_CINIT: begin
            idx_in = '0; csum_in = '0; mode_in = 1'b1;
            state_in = ST_FETCH;
         end
         ST_FETCH: state_in = ST_MT;
         ST_MT: begin
            mul_a = 33'(b_ff);  mul_b = 33'(x_rd_ff);
            state_in = ST_MY;
         end
         ST_MY: begin
            mul_a = 33'(t_c);   mul_b = $signed(LOG2E_Q30);
            state_in = ST_TAB;
         end
         ST_TAB: begin
            k_in   = y_full[23:16];
            r_in   = 16'({f_w[15-TAB_BITS:0], {TAB_BITS{1'b0}}});
            lo_in  = EXP_TAB[ti];
            dlt_in = EXP_TAB[ti_hi] - EXP_TAB[ti];
            state_in = ST_INT;
         end
         ST_INT: begin
            mul_a = $signed(dlt_ff);  mul_b = $signed({17'd0, r_ff});
            state_in = ST_SCL;
         end
         ST_SCL: begin
            e_in = e_w;
            state_in = ST_PRED;
         end
         ST_PRED: begin
            mul_a = 33'(a_ff);  mul_b = $signed({1'b0, e_ff});
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            d_in = sat32(68'(pred_w) - 68'(y_rd_ff));
            state_in = ST_DMUL;
         end
         ST_DMUL: begin
            mul_a = 33'(d_ff);
            mul_b = mode_ff ? 33'(d_ff) : $signed({1'b0, e_ff});
            state_in = mode_ff ? ST_CACC : ST_G1;
         end
         ST_G1: begin
            sa_in = sadd64(sa_ff, g_w);
            mul_a = 33'(g_w);  mul_b = 33'(a_ff);
            state_in = ST_G2;
         end
         ST_G2: begin
            mul_a = 33'(g_w);  mul_b = 33'(x_rd_ff);
            state_in = ST_G3;
         end
         ST_G3: begin
            sb_in = sadd64(sb_ff, g_w);
            if (last_pt) state_in = ST_DA_GO;
            else begin
               idx_in = idx_ff + CW'(1);
               state_in = ST_FETCH;
            end
         end
         ST_CACC: begin
            csum_in = csum_w[64] ? {64{1'b1}} : csum_w[63:0];
            if (last_pt) state_in = ST_CD_GO;
            else begin
               idx_in = idx_ff + CW'(1);
               state_in = ST_FETCH;
            end
         end
         ST_DA_GO: begin
            div_start = 1'b1;
            div_dvd   = sa_ff[63] ? 64'(-sa_ff) : sa_ff;
            state_in  = ST_DA_WT;
         end
         ST_DA_WT: begin
            q_s = sa_ff[63] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
            if (div_done) begin
               ma_in = sat32(68'(q_s));
               state_in = ST_DB_GO;
            end
         end
         ST_DB_GO: begin
            div_start = 1'b1;
            div_dvd   = sb_ff[63] ? 64'(-sb_ff) : sb_ff;
            state_in  = ST_DB_WT;
         end
         ST_DB_WT: begin
            q_s = sb_ff[63] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
            if (div_done) begin
               mb_in = sat32(68'(q_s));
               state_in = ST_UA;
            end
         end
         ST_UA: begin
            mul_a = $signed({1'b0, learn_rate_ff});  mul_b = 33'(ma_ff);
            state_in = ST_UA2;
         end
         ST_UA2: begin
            na_w  = sat32(68'(a_ff) - 68'(prod_ff >>> 32));
            a_in  = na_w;
            da_in = 33'(na_w) - 33'(a_ff);
            state_in = ST_UB;
         end
         ST_UB: begin
            mul_a = $signed({1'b0, learn_rate_ff});  mul_b = 33'(mb_ff);
            state_in = ST_UB2;
         end
         ST_UB2: begin
            na_w    = sat32(68'(b_ff) - 68'(prod_ff >>> 32));
            b_in    = na_w;
            db_in   = 33'(na_w) - 33'(b_ff);
            pass_in = pass_ff + 18'd1;
            state_in = ST_CV_DA;
         end
         ST_CV_DA: begin
            mul_a = da_ff;  mul_b = da_ff;
            state_in = ST_CV_DB;
         end
         ST_CV_DB: begin
            sq_in = prod_ff[32:0];
            mul_a = db_ff;  mul_b = db_ff;
            state_in = ST_CV_EE;
         end
         ST_CV_EE: begin
            s_in  = {1'b0, sq_ff} + {1'b0, prod_ff[32:0]};
            mul_a = $signed({1'b0, stop_step_ff});  mul_b = $signed({1'b0, stop_step_ff});
            state_in = ST_CV_CMP;
         end
         ST_CV_CMP: begin
            // squared step against squared threshold, exact
            if (in_range && (s_ff[33:32] == 2'd0) &&
                ({s_ff[31:0], 32'd0} < prod_ff[63:0])) begin
               conv_in  = 1'b1;
               state_in = ST_CINIT;
            end else begin
               state_in = ST_PCHK;
            end
         end
         ST_CD_GO: begin
            div_start = 1'b1;
            div_dvd   = csum_ff;
            state_in  = ST_CD_WT;
         end
         ST_CD_WT: begin
            if (div_done) begin
               cost_in  = (div_q[63:48] != 16'd0) ? 32'hFFFF_FFFF : div_q[47:16];
               state_in = ST_OUT;
            end
         end
         ST_OUT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         n_ff          <= '0;
         idx_ff        <= '0;
         mode_ff       <= 1'b0;
         a_ff          <= '0;
         b_ff          <= '0;
         pass_ff       <= '0;
         conv_ff       <= 1'b0;
         init_a_ff     <= INIT_A_RST;
         init_b_ff     <= INIT_B_RST;
         learn_rate_ff <= LEARN_RATE_RST;
         stop_step_ff  <= STOP_STEP_RST;
         pass_limit_ff <= PASS_LIMIT_RST;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         n_ff     <= n_in;
         idx_ff   <= idx_in;
         mode_ff  <= mode_in;
         a_ff     <= a_in;
         b_ff     <= b_in;
         pass_ff  <= pass_in;
         conv_ff  <= conv_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_idx_type'(csr_index))
               CSR_INIT_A:     init_a_ff     <= csr_data;
               CSR_INIT_B:     init_b_ff     <= csr_data;
               CSR_LEARN_RATE: learn_rate_ff <= csr_data;
               CSR_STOP_STEP:  stop_step_ff  <= csr_data;
               CSR_PASS_LIMIT: pass_limit_ff <= csr_data[17:0];
               default: ;
            endcase
         end
      end
      cost_ff <= cost_in;
      prod_ff <= prod_in;
      k_ff    <= k_in;
      r_ff    <= r_in;
      lo_ff   <= lo_in;
      dlt_ff  <= dlt_in;
      e_ff    <= e_in;
      d_ff    <= d_in;
      sa_ff   <= sa_in;
      sb_ff   <= sb_in;
      csum_ff <= csum_in;
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      da_ff   <= da_in;
      db_ff   <= db_in;
      sq_ff   <= sq_in;
      s_ff    <= s_in;
   end

   // store: write at load, registered read at the point index
   always_ff @(posedge clock) begin
      if (accept && (cnt_ff < CW'(MAX_POINTS))) begin
         x_mem[cnt_ff[AW-1:0]] <= req_sample_x;
         y_mem[cnt_ff[AW-1:0]] <= req_sample_y;
      end
      x_rd_ff <= x_mem[idx_ff[AW-1:0]];
      y_rd_ff <= y_mem[idx_ff[AW-1:0]];
   end

   emgf_div #(
      .DVW(DVW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rsp_valid      = (state_ff == ST_OUT);
   assign rsp_fit_a      = a_ff;
   assign rsp_fit_b      = b_ff;
   assign rsp_fit_cost   = cost_ff;
   assign rsp_passes_run = pass_ff;
   assign rsp_converged  = conv_ff;

`ifndef SYNTH
   // a result only comes out of a running fit, and the block frees up right after it
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside a fit");
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("block still busy after result");
   // point walk stays inside the batch
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |-> (idx_ff < n_ff)) else $error("point index past batch");
`endif

endmodule

`default_nettype wire
